// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL. In synthesis builds they expand to nothing.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// The condition must never be true outside reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)

`endif

`endif

// ===== hdl/i2cm_rt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2cm_rt_pkg;

  // Command codes carried by the func field.
  typedef enum logic [2:0] {
    FN_TICK  = 3'd0,
    FN_WRITE = 3'd1,
    FN_READ  = 3'd2,
    FN_PROBE = 3'd3,
    FN_DATA  = 3'd4
  } func_t;

  // Kind of the running transfer.
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_PROBE = 2'd3
  } kind_t;

  // What the byte being shifted out stands for, which decides the ACK handling.
  typedef enum logic [1:0] {
    ROLE_ADDR_W = 2'd0,
    ROLE_SUB    = 2'd1,
    ROLE_DATA   = 2'd2,
    ROLE_ADDR_R = 2'd3
  } role_t;

  // Completion status reported with done.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NACK_ADDR  = 3'd1,
    ST_NACK_SUB   = 3'd2,
    ST_NACK_DATA  = 3'd3,
    ST_NACK_RADDR = 3'd4
  } status_t;

  // Bus phase sequencer, one-hot.
  typedef enum logic [18:0] {
    PH_IDLE      = 19'd1 << 0,
    PH_START_SDA = 19'd1 << 1,
    PH_START_SCL = 19'd1 << 2,
    PH_TX_LOW    = 19'd1 << 3,
    PH_TX_HIGH   = 19'd1 << 4,
    PH_ACK_REL   = 19'd1 << 5,
    PH_ACK_RISE  = 19'd1 << 6,
    PH_ACK_WAIT  = 19'd1 << 7,
    PH_WAIT_DATA = 19'd1 << 8,
    PH_RS_HIGH   = 19'd1 << 9,
    PH_RD_LOW    = 19'd1 << 10,
    PH_RD_HIGH   = 19'd1 << 11,
    PH_RD_SAMPLE = 19'd1 << 12,
    PH_MA_LOW    = 19'd1 << 13,
    PH_MA_HIGH   = 19'd1 << 14,
    PH_MA_END    = 19'd1 << 15,
    PH_STOP_LOW  = 19'd1 << 16,
    PH_STOP_SCL  = 19'd1 << 17,
    PH_STOP_SDA  = 19'd1 << 18
  } phase_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TMO    = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [6:0] DEV_ADDR_RST   = 7'd0;
  localparam logic [1:0] ADDR_BYTES_RST = 2'd1;
  localparam logic [7:0] ACK_TMO_RST    = 8'd101;

  // One result transaction.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [7:0] read_data;
    logic       read_valid;
    logic       data_request;
    logic       busy_res;
    logic       done_res;
    status_t    status;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/i2c_master_register_transfer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Contents
// in_      input      in_valid / in_stall   func, sub_address, byte_count, write_data, sda_in
// out_     output     out_valid / out_stall line drives, read byte, request, busy, done, status
// cfg_     input      cfg_valid / cfg_ready register index and write data
//
// Each input transaction advances the phase sequencer once, in the cycle it is accepted;
// its result is registered in the output register, or in the skid register behind it when
// the output register still holds a result held back by out_stall. One transaction can be
// taken every cycle while in_stall is low; in_stall rises only while the skid is occupied.
// Reset (rst_n low, synchronous) returns the sequencer to idle, releases both lines and
// loads the configuration reset values. cfg_ready is always high.
`include "assert_macros.svh"

module i2c_master_register_transfer_unit
  import i2cm_rt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [2:0]           in_func,
  input  wire logic [15:0]          in_sub_address,
  input  wire logic [15:0]          in_byte_count,
  input  wire logic [7:0]           in_write_data,
  input  wire logic                 in_sda_in,
  // Result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_scl_level,
  output logic                      out_sda_level,
  output logic [7:0]                out_read_data,
  output logic                      out_read_valid,
  output logic                      out_data_request,
  output logic                      out_busy_res,
  output logic                      out_done_res,
  output logic [2:0]                out_status,
  // Configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  // Configuration registers
  logic [6:0] dev_addr_r;
  logic [1:0] addr_bytes_r;
  logic [7:0] ack_tmo_r;

  // Sequencer state
  phase_t     phase_r, phase_nxt;
  logic [3:0] bit_index_r, bit_index_nxt;
  logic [7:0] shift_byte_r, shift_byte_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [15:0] held_sub_r, held_sub_nxt;
  logic [1:0] addr_left_r, addr_left_nxt;
  logic [7:0] ack_wait_r, ack_wait_nxt;
  kind_t      kind_r, kind_nxt;
  logic       restart_done_r, restart_done_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  role_t      role_r, role_nxt;
  status_t    pend_status_r, pend_status_nxt;

  // Output register and skid register
  res_t res_nxt;
  res_t out_r, skid_r;
  logic out_valid_r, skid_valid_r;

  logic       in_acc;
  logic       out_fire;
  logic [1:0] ack_rem;
  logic [15:0] bytes_dec;
  logic [7:0] rd_shift;
  logic [3:0] bit_inc;
  logic [7:0] read_data_nxt;
  logic       read_valid_nxt;
  logic       done_nxt;
  status_t    status_nxt;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_fire  = out_valid_r && !out_stall;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r   <= DEV_ADDR_RST;
      addr_bytes_r <= ADDR_BYTES_RST;
      ack_tmo_r    <= ACK_TMO_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEV_ADDR:   dev_addr_r   <= cfg_data[6:0];
        CFG_ADDR_BYTES: addr_bytes_r <= cfg_data[1:0];
        CFG_ACK_TMO:    ack_tmo_r    <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Helper values for the sequencer.
  assign ack_rem   = (role_r == ROLE_SUB) ? (addr_left_r - 2'd1) : addr_left_r;
  assign bytes_dec = bytes_left_r - 16'd1;
  assign rd_shift  = {shift_byte_r[6:0], in_sda_in};
  assign bit_inc   = bit_index_r + 4'd1;

  // Next state of the phase sequencer for the transaction at the input.
  always_comb begin
    phase_nxt        = phase_r;
    bit_index_nxt    = bit_index_r;
    shift_byte_nxt   = shift_byte_r;
    bytes_left_nxt   = bytes_left_r;
    held_sub_nxt     = held_sub_r;
    addr_left_nxt    = addr_left_r;
    ack_wait_nxt     = ack_wait_r;
    kind_nxt         = kind_r;
    restart_done_nxt = restart_done_r;
    scl_nxt          = scl_r;
    sda_nxt          = sda_r;
    role_nxt         = role_r;
    pend_status_nxt  = pend_status_r;
    read_data_nxt    = 8'd0;
    read_valid_nxt   = 1'b0;
    done_nxt         = 1'b0;
    status_nxt       = ST_OK;

    if (phase_r == PH_IDLE) begin
      // A begin command latches the transfer and raises START.
      if (in_func == FN_WRITE || in_func == FN_READ || in_func == FN_PROBE) begin
        case (in_func)
          FN_WRITE: kind_nxt = KIND_WRITE;
          FN_READ:  kind_nxt = KIND_READ;
          default:  kind_nxt = KIND_PROBE;
        endcase
        held_sub_nxt     = in_sub_address;
        restart_done_nxt = 1'b0;
        pend_status_nxt  = ST_OK;
        ack_wait_nxt     = 8'd0;
        bit_index_nxt    = 4'd0;
        shift_byte_nxt   = 8'd0;
        if (in_func == FN_PROBE) begin
          bytes_left_nxt = 16'd1;
          addr_left_nxt  = 2'd0;
        end else begin
          bytes_left_nxt = in_byte_count;
          addr_left_nxt  = (addr_bytes_r == 2'd3) ? 2'd2 : addr_bytes_r;
        end
        scl_nxt   = 1'b1;
        sda_nxt   = 1'b1;
        phase_nxt = PH_START_SDA;
      end
    end else if (phase_r == PH_WAIT_DATA) begin
      // Waiting for the next write byte.
      if (in_func == FN_DATA) begin
        shift_byte_nxt = in_write_data;
        bit_index_nxt  = 4'd0;
        role_nxt       = ROLE_DATA;
        phase_nxt      = PH_TX_LOW;
      end
    end else if (in_func == FN_TICK) begin
      case (phase_r)
        PH_START_SDA: begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_START_SCL;
        end
        PH_START_SCL: begin
          scl_nxt       = 1'b0;
          bit_index_nxt = 4'd0;
          phase_nxt     = PH_TX_LOW;
          if (kind_r == KIND_WRITE || (kind_r == KIND_READ && !restart_done_r)) begin
            shift_byte_nxt = {dev_addr_r, 1'b0};
            role_nxt       = ROLE_ADDR_W;
          end else begin
            shift_byte_nxt = {dev_addr_r, 1'b1};
            role_nxt       = ROLE_ADDR_R;
          end
        end
        PH_TX_LOW: begin
          scl_nxt   = 1'b0;
          sda_nxt   = shift_byte_r[7];
          phase_nxt = PH_TX_HIGH;
        end
        PH_TX_HIGH: begin
          scl_nxt        = 1'b1;
          shift_byte_nxt = {shift_byte_r[6:0], 1'b0};
          bit_index_nxt  = bit_inc;
          phase_nxt      = (bit_inc >= 4'd8) ? PH_ACK_REL : PH_TX_LOW;
        end
        PH_ACK_REL: begin
          scl_nxt   = 1'b0;
          sda_nxt   = 1'b1;
          phase_nxt = PH_ACK_RISE;
        end
        PH_ACK_RISE: begin
          scl_nxt      = 1'b1;
          ack_wait_nxt = 8'd0;
          phase_nxt    = PH_ACK_WAIT;
        end
        PH_ACK_WAIT: begin
          if (!in_sda_in) begin
            // ACK seen: move on according to the byte just sent.
            scl_nxt = 1'b0;
            if (role_r == ROLE_ADDR_W || role_r == ROLE_SUB) begin
              addr_left_nxt = ack_rem;
              if (ack_rem != 2'd0) begin
                shift_byte_nxt = (ack_rem == 2'd2) ? held_sub_r[15:8] : held_sub_r[7:0];
                bit_index_nxt  = 4'd0;
                role_nxt       = ROLE_SUB;
                phase_nxt      = PH_TX_LOW;
              end else if (kind_r == KIND_WRITE) begin
                phase_nxt = (bytes_left_r == 16'd0) ? PH_STOP_LOW : PH_WAIT_DATA;
              end else begin
                restart_done_nxt = 1'b1;
                phase_nxt        = PH_RS_HIGH;
              end
            end else if (role_r == ROLE_DATA) begin
              bytes_left_nxt = bytes_dec;
              phase_nxt      = (bytes_dec == 16'd0) ? PH_STOP_LOW : PH_WAIT_DATA;
            end else if (bytes_left_r == 16'd0) begin
              phase_nxt = PH_STOP_LOW;
            end else begin
              bit_index_nxt  = 4'd0;
              shift_byte_nxt = 8'd0;
              phase_nxt      = PH_RD_LOW;
            end
          end else if (ack_wait_r >= ack_tmo_r) begin
            // Timed out without ACK: abort with STOP.
            scl_nxt = 1'b0;
            case (role_r)
              ROLE_ADDR_W: pend_status_nxt = ST_NACK_ADDR;
              ROLE_SUB:    pend_status_nxt = ST_NACK_SUB;
              ROLE_DATA:   pend_status_nxt = ST_NACK_DATA;
              default:     pend_status_nxt = (kind_r == KIND_PROBE) ? ST_NACK_ADDR
                                                                     : ST_NACK_RADDR;
            endcase
            phase_nxt = PH_STOP_LOW;
          end else begin
            ack_wait_nxt = ack_wait_r + 8'd1;
          end
        end
        PH_RS_HIGH: begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          phase_nxt = PH_START_SDA;
        end
        PH_RD_LOW: begin
          scl_nxt   = 1'b0;
          sda_nxt   = 1'b1;
          phase_nxt = PH_RD_HIGH;
        end
        PH_RD_HIGH: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_RD_SAMPLE;
        end
        PH_RD_SAMPLE: begin
          shift_byte_nxt = rd_shift;
          bit_index_nxt  = bit_inc;
          if (bit_inc >= 4'd8) begin
            read_data_nxt  = rd_shift;
            read_valid_nxt = 1'b1;
            phase_nxt      = PH_MA_LOW;
          end else begin
            phase_nxt = PH_RD_LOW;
          end
        end
        PH_MA_LOW: begin
          // ACK while more bytes follow, NACK on the last one.
          scl_nxt   = 1'b0;
          sda_nxt   = (bytes_left_r > 16'd1) ? 1'b0 : 1'b1;
          phase_nxt = PH_MA_HIGH;
        end
        PH_MA_HIGH: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_MA_END;
        end
        PH_MA_END: begin
          scl_nxt        = 1'b0;
          bytes_left_nxt = bytes_dec;
          if (bytes_dec == 16'd0) begin
            phase_nxt = PH_STOP_LOW;
          end else begin
            bit_index_nxt  = 4'd0;
            shift_byte_nxt = 8'd0;
            phase_nxt      = PH_RD_LOW;
          end
        end
        PH_STOP_LOW: begin
          scl_nxt   = 1'b0;
          sda_nxt   = 1'b0;
          phase_nxt = PH_STOP_SCL;
        end
        PH_STOP_SCL: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_STOP_SDA;
        end
        PH_STOP_SDA: begin
          sda_nxt         = 1'b1;
          done_nxt        = 1'b1;
          status_nxt      = pend_status_r;
          pend_status_nxt = ST_OK;
          kind_nxt        = KIND_NONE;
          phase_nxt       = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    res_nxt.scl_level    = scl_nxt;
    res_nxt.sda_level    = sda_nxt;
    res_nxt.read_data    = read_data_nxt;
    res_nxt.read_valid   = read_valid_nxt;
    res_nxt.data_request = (phase_nxt == PH_WAIT_DATA);
    res_nxt.busy_res     = (phase_nxt != PH_IDLE);
    res_nxt.done_res     = done_nxt;
    res_nxt.status       = status_nxt;
  end

  // Sequencer registers advance once per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      bit_index_r    <= 4'd0;
      shift_byte_r   <= 8'd0;
      bytes_left_r   <= 16'd0;
      held_sub_r     <= 16'd0;
      addr_left_r    <= 2'd0;
      ack_wait_r     <= 8'd0;
      kind_r         <= KIND_NONE;
      restart_done_r <= 1'b0;
      scl_r          <= 1'b1;
      sda_r          <= 1'b1;
      role_r         <= ROLE_ADDR_W;
      pend_status_r  <= ST_OK;
    end else if (in_acc) begin
      phase_r        <= phase_nxt;
      bit_index_r    <= bit_index_nxt;
      shift_byte_r   <= shift_byte_nxt;
      bytes_left_r   <= bytes_left_nxt;
      held_sub_r     <= held_sub_nxt;
      addr_left_r    <= addr_left_nxt;
      ack_wait_r     <= ack_wait_nxt;
      kind_r         <= kind_nxt;
      restart_done_r <= restart_done_nxt;
      scl_r          <= scl_nxt;
      sda_r          <= sda_nxt;
      role_r         <= role_nxt;
      pend_status_r  <= pend_status_nxt;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_r && !out_fire) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payloads.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_acc) begin
      if (out_valid_r && !out_fire) begin
        skid_r <= res_nxt;
      end else begin
        out_r <= res_nxt;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_scl_level    = out_r.scl_level;
  assign out_sda_level    = out_r.sda_level;
  assign out_read_data    = out_r.read_data;
  assign out_read_valid   = out_r.read_valid;
  assign out_data_request = out_r.data_request;
  assign out_busy_res     = out_r.busy_res;
  assign out_done_res     = out_r.done_res;
  assign out_status       = out_r.status;

  // The skid entry is only ever filled behind a waiting output transaction.
  `ASSERT_CLK(a_skid_behind_out, skid_valid_r |-> out_valid_r)
  // A finished transfer reports idle in the same transaction.
  `ASSERT_NEVER(a_done_not_busy, out_valid_r && out_r.done_res && out_r.busy_res)
  // A status other than ok only comes with done.
  `ASSERT_NEVER(a_status_with_done,
                out_valid_r && (out_r.status != ST_OK) && !out_r.done_res)
  // A received byte is reported only while a transfer is still running.
  `ASSERT_NEVER(a_read_in_transfer, out_valid_r && out_r.read_valid && !out_r.busy_res)

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import i2cm_rt_pkg::*;

  // Function codes that the block ignores in every state.
  localparam logic [2:0] FN_SPARE_LO  = 3'd5;
  localparam logic [2:0] FN_SPARE_MID = 3'd6;
  localparam logic [2:0] FN_SPARE_HI  = 3'd7;

  // One input transaction.
  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] sub;
    logic [15:0] cnt;
    logic [7:0]  wdata;
    logic        sda;
  } cmd_t;

  // One row of the directed table; typed rows carry their own expected result.
  typedef struct {
    cmd_t cmd;
    bit   typed;
    res_t want;
  } row_t;

  localparam res_t IDLE_LINES = '{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK};
  localparam res_t BUSY_LINES = '{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, ST_OK};
  localparam res_t START_LOW  = '{1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, ST_OK};
  localparam res_t START_HOLD = '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, ST_OK};

  // Directed table: idle no-ops, a probe, ignored commands while busy, the START.
  row_t dir_rows [16] = '{
    '{'{FN_TICK,      16'h0000, 16'h0000, 8'h00, 1'b0}, 1'b1, IDLE_LINES},
    '{'{FN_DATA,      16'h0000, 16'h0000, 8'hFF, 1'b1}, 1'b1, IDLE_LINES},
    '{'{FN_SPARE_LO,  16'h5555, 16'hAAAA, 8'h55, 1'b0}, 1'b1, IDLE_LINES},
    '{'{FN_SPARE_MID, 16'hAAAA, 16'h5555, 8'hAA, 1'b1}, 1'b1, IDLE_LINES},
    '{'{FN_SPARE_HI,  16'hFFFF, 16'hFFFF, 8'hFF, 1'b1}, 1'b1, IDLE_LINES},
    '{'{FN_TICK,      16'hFFFF, 16'hFFFF, 8'hFF, 1'b1}, 1'b1, IDLE_LINES},
    '{'{FN_PROBE,     16'h1234, 16'hFFFF, 8'h00, 1'b0}, 1'b1, BUSY_LINES},
    '{'{FN_WRITE,     16'hFFFF, 16'h0000, 8'hFF, 1'b0}, 1'b1, BUSY_LINES},
    '{'{FN_READ,      16'h0000, 16'hFFFF, 8'h00, 1'b1}, 1'b1, BUSY_LINES},
    '{'{FN_DATA,      16'hABCD, 16'h0001, 8'h5A, 1'b0}, 1'b1, BUSY_LINES},
    '{'{FN_SPARE_HI,  16'h0000, 16'h0000, 8'h00, 1'b0}, 1'b1, BUSY_LINES},
    '{'{FN_TICK,      16'h0000, 16'h0000, 8'h00, 1'b1}, 1'b1, START_LOW},
    '{'{FN_TICK,      16'h0000, 16'h0000, 8'h00, 1'b0}, 1'b1, START_HOLD},
    '{'{FN_TICK,      16'h0F0F, 16'hF0F0, 8'h0F, 1'b0}, 1'b0, IDLE_LINES},
    '{'{FN_TICK,      16'hF0F0, 16'h0F0F, 8'hF0, 1'b1}, 1'b0, IDLE_LINES},
    '{'{FN_TICK,      16'h0000, 16'h0000, 8'h00, 1'b0}, 1'b0, IDLE_LINES}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_func = FN_TICK;
  logic [15:0] in_sub_address = '0;
  logic [15:0] in_byte_count = '0;
  logic [7:0]  in_write_data = '0;
  logic        in_sda_in = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_scl_level;
  logic        out_sda_level;
  logic [7:0]  out_read_data;
  logic        out_read_valid;
  logic        out_data_request;
  logic        out_busy_res;
  logic        out_done_res;
  logic [2:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEV_ADDR;
  logic [7:0]  cfg_data = '0;

  // Configuration as the bus sequencer sees it.
  logic [6:0] dev_addr_reg   = DEV_ADDR_RST;
  logic [1:0] addr_bytes_reg = ADDR_BYTES_RST;
  logic [7:0] ack_tmo_reg    = ACK_TMO_RST;

  // Sequencer state as predicted from the accepted transactions.
  phase_t      bus_phase   = PH_IDLE;
  logic [3:0]  bit_cnt     = '0;
  logic [7:0]  shreg       = '0;
  logic [15:0] bytes_left  = '0;
  logic [15:0] sub_hold    = '0;
  logic [1:0]  sub_left    = '0;
  logic [7:0]  ack_wait    = '0;
  kind_t       xfer_kind   = KIND_NONE;
  logic        restarted   = 1'b0;
  logic        scl_drv     = 1'b1;
  logic        sda_drv     = 1'b1;
  role_t       byte_role   = ROLE_ADDR_W;
  status_t     held_status = ST_OK;

  res_t awaited_results [$];
  int   mismatch_count = 0;
  bit   abort_planned = 1'b0;
  int   in_calm = 0;
  int   out_calm = 0;
  int   stall_left = 0;

  i2c_master_register_transfer_unit dut (.*);

  always #4 clk = ~clk;

  // Bus sequencer prediction helpers.
  function automatic void load_tx_byte(input logic [7:0] value, input role_t role);
    shreg = value;
    bit_cnt = '0;
    byte_role = role;
    bus_phase = PH_TX_LOW;
  endfunction

  function automatic void next_write_step();
    bus_phase = (bytes_left == 0) ? PH_STOP_LOW : PH_WAIT_DATA;
  endfunction

  function automatic void start_rx_byte();
    bit_cnt = '0;
    shreg = '0;
    bus_phase = PH_RD_LOW;
  endfunction

  // Once the address byte or a sub-address byte is acknowledged, pick what follows.
  function automatic void after_address_byte();
    if (sub_left != 0) begin
      load_tx_byte((sub_left == 2) ? sub_hold[15:8] : sub_hold[7:0], ROLE_SUB);
    end else if (xfer_kind == KIND_WRITE) begin
      next_write_step();
    end else begin
      restarted = 1'b1;
      bus_phase = PH_RS_HIGH;
    end
  endfunction

  // Moves the predicted sequencer by one transaction and returns its result.
  function automatic res_t advance_bus(input cmd_t c);
    res_t r;
    r = '0;
    if (bus_phase == PH_IDLE) begin
      if (c.func inside {FN_WRITE, FN_READ, FN_PROBE}) begin
        xfer_kind = kind_t'(c.func[1:0]);
        sub_hold = c.sub;
        restarted = 1'b0;
        held_status = ST_OK;
        ack_wait = '0;
        bit_cnt = '0;
        shreg = '0;
        if (c.func == FN_PROBE) begin
          bytes_left = 16'd1;
          sub_left = '0;
        end else begin
          bytes_left = c.cnt;
          sub_left = (addr_bytes_reg > 2) ? 2'd2 : addr_bytes_reg;
        end
        scl_drv = 1'b1;
        sda_drv = 1'b1;
        bus_phase = PH_START_SDA;
      end
    end else if (bus_phase == PH_WAIT_DATA) begin
      if (c.func == FN_DATA) load_tx_byte(c.wdata, ROLE_DATA);
    end else if (c.func == FN_TICK) begin
      case (bus_phase)
        PH_START_SDA: begin
          sda_drv = 1'b0;
          bus_phase = PH_START_SCL;
        end
        PH_START_SCL: begin
          scl_drv = 1'b0;
          if (xfer_kind == KIND_WRITE || (xfer_kind == KIND_READ && !restarted))
            load_tx_byte({dev_addr_reg, 1'b0}, ROLE_ADDR_W);
          else
            load_tx_byte({dev_addr_reg, 1'b1}, ROLE_ADDR_R);
        end
        PH_TX_LOW: begin
          scl_drv = 1'b0;
          sda_drv = shreg[7];
          bus_phase = PH_TX_HIGH;
        end
        PH_TX_HIGH: begin
          scl_drv = 1'b1;
          shreg = shreg << 1;
          bit_cnt = bit_cnt + 1'b1;
          bus_phase = (bit_cnt >= 8) ? PH_ACK_REL : PH_TX_LOW;
        end
        PH_ACK_REL: begin
          scl_drv = 1'b0;
          sda_drv = 1'b1;
          bus_phase = PH_ACK_RISE;
        end
        PH_ACK_RISE: begin
          scl_drv = 1'b1;
          ack_wait = '0;
          bus_phase = PH_ACK_WAIT;
        end
        PH_ACK_WAIT: begin
          // A low SDA is an ACK; a high one is tolerated until the timeout runs out.
          if (!c.sda) begin
            scl_drv = 1'b0;
            case (byte_role)
              ROLE_ADDR_W: after_address_byte();
              ROLE_SUB: begin
                sub_left = sub_left - 1'b1;
                after_address_byte();
              end
              ROLE_DATA: begin
                bytes_left = bytes_left - 1'b1;
                next_write_step();
              end
              default: begin
                if (bytes_left == 0) bus_phase = PH_STOP_LOW;
                else start_rx_byte();
              end
            endcase
          end else if (ack_wait >= ack_tmo_reg) begin
            scl_drv = 1'b0;
            case (byte_role)
              ROLE_ADDR_W: held_status = ST_NACK_ADDR;
              ROLE_SUB:    held_status = ST_NACK_SUB;
              ROLE_DATA:   held_status = ST_NACK_DATA;
              default:     held_status = (xfer_kind == KIND_PROBE) ? ST_NACK_ADDR : ST_NACK_RADDR;
            endcase
            bus_phase = PH_STOP_LOW;
          end else begin
            ack_wait = ack_wait + 1'b1;
          end
        end
        PH_RS_HIGH: begin
          scl_drv = 1'b1;
          sda_drv = 1'b1;
          bus_phase = PH_START_SDA;
        end
        PH_RD_LOW: begin
          scl_drv = 1'b0;
          sda_drv = 1'b1;
          bus_phase = PH_RD_HIGH;
        end
        PH_RD_HIGH: begin
          scl_drv = 1'b1;
          bus_phase = PH_RD_SAMPLE;
        end
        PH_RD_SAMPLE: begin
          shreg = {shreg[6:0], c.sda};
          bit_cnt = bit_cnt + 1'b1;
          if (bit_cnt >= 8) begin
            r.read_data = shreg;
            r.read_valid = 1'b1;
            bus_phase = PH_MA_LOW;
          end else begin
            bus_phase = PH_RD_LOW;
          end
        end
        PH_MA_LOW: begin
          // ACK every byte but the last, which gets a NACK.
          scl_drv = 1'b0;
          sda_drv = (bytes_left > 1) ? 1'b0 : 1'b1;
          bus_phase = PH_MA_HIGH;
        end
        PH_MA_HIGH: begin
          scl_drv = 1'b1;
          bus_phase = PH_MA_END;
        end
        PH_MA_END: begin
          scl_drv = 1'b0;
          bytes_left = bytes_left - 1'b1;
          if (bytes_left == 0) bus_phase = PH_STOP_LOW;
          else start_rx_byte();
        end
        PH_STOP_LOW: begin
          scl_drv = 1'b0;
          sda_drv = 1'b0;
          bus_phase = PH_STOP_SCL;
        end
        PH_STOP_SCL: begin
          scl_drv = 1'b1;
          bus_phase = PH_STOP_SDA;
        end
        default: begin
          sda_drv = 1'b1;
          r.done_res = 1'b1;
          r.status = held_status;
          held_status = ST_OK;
          xfer_kind = KIND_NONE;
          bus_phase = PH_IDLE;
        end
      endcase
    end
    r.scl_level = scl_drv;
    r.sda_level = sda_drv;
    r.data_request = (bus_phase == PH_WAIT_DATA);
    r.busy_res = (bus_phase != PH_IDLE);
    return r;
  endfunction

  // Idle lengths: mostly none or short, a few long, with calm stretches in between.
  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Chooses the next transaction from the predicted state: mostly well-formed
  // transfers, with some ignored commands mixed in as noise.
  function automatic cmd_t make_cmd(input bit winding_down, output bit counted);
    cmd_t c;
    int   pick;
    c.func = FN_TICK;
    c.sub = 16'($urandom);
    c.cnt = 16'($urandom);
    c.wdata = 8'($urandom);
    c.sda = 1'($urandom);
    counted = 1'b1;
    if (!winding_down && $urandom_range(0, 99) < ((bus_phase == PH_IDLE) ? 15 : 6)) begin
      counted = 1'b0;
      do c.func = 3'($urandom_range(0, 7));
      while ((bus_phase == PH_IDLE && c.func inside {FN_WRITE, FN_READ, FN_PROBE}) ||
             (bus_phase == PH_WAIT_DATA && c.func == FN_DATA) ||
             (bus_phase != PH_IDLE && bus_phase != PH_WAIT_DATA && c.func == FN_TICK));
    end else if (bus_phase == PH_IDLE) begin
      pick = $urandom_range(0, 2);
      c.func = (pick == 0) ? FN_WRITE : (pick == 1) ? FN_READ : FN_PROBE;
      c.cnt = ($urandom_range(0, 11) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    end else if (bus_phase == PH_WAIT_DATA) begin
      c.func = FN_DATA;
    end else if (bus_phase == PH_ACK_WAIT) begin
      // Long transfers are cut short by withholding the first data or read-address ACK.
      if (abort_planned && (byte_role == ROLE_DATA || byte_role == ROLE_ADDR_R))
        c.sda = 1'b1;
      else
        c.sda = ($urandom_range(0, 99) < 20);
    end
    return c;
  endfunction

  task automatic pace_input();
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Presents one transaction, waits for it to be taken and records what must come back.
  task automatic send_item(input cmd_t c, input bit typed, input res_t want);
    res_t predicted;
    in_valid <= 1'b1;
    in_func <= c.func;
    in_sub_address <= c.sub;
    in_byte_count <= c.cnt;
    in_write_data <= c.wdata;
    in_sda_in <= c.sda;
    do @(posedge clk); while (in_stall);
    predicted = advance_bus(c);
    awaited_results.push_back(typed ? want : predicted);
  endtask

  task automatic run_phase(input int budget);
    int   taken;
    bit   counted;
    bit   was_idle;
    cmd_t c;
    taken = 0;
    while (taken < budget || bus_phase != PH_IDLE) begin
      c = make_cmd(taken >= budget, counted);
      pace_input();
      was_idle = (bus_phase == PH_IDLE);
      send_item(c, 1'b0, IDLE_LINES);
      if (was_idle && bus_phase != PH_IDLE) abort_planned = (bytes_left > 4);
      if (counted) taken++;
    end
  endtask

  // Stops sending and waits until every result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Writes all three registers back to back with the valid held high.
  task automatic program_regs(input logic [7:0] dev_v, input logic [7:0] abytes_v,
                              input logic [7:0] tmo_v);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DEV_ADDR;
    cfg_data <= dev_v;
    do @(posedge clk); while (!cfg_ready);
    dev_addr_reg = dev_v[6:0];
    cfg_index <= CFG_ADDR_BYTES;
    cfg_data <= abytes_v;
    do @(posedge clk); while (!cfg_ready);
    addr_bytes_reg = abytes_v[1:0];
    cfg_index <= CFG_ACK_TMO;
    cfg_data <= tmo_v;
    do @(posedge clk); while (!cfg_ready);
    ack_tmo_reg = tmo_v;
    cfg_valid <= 1'b0;
  endtask

  // The receiving side stalls at random.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap(out_calm);
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want_v,
                                      input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  // Every result transaction is compared with the oldest one awaited.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result transaction with nothing awaited");
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("scl_level", want.scl_level, out_scl_level);
        check_field("sda_level", want.sda_level, out_sda_level);
        check_field("read_data", want.read_data, out_read_data);
        check_field("read_valid", want.read_valid, out_read_valid);
        check_field("data_request", want.data_request, out_data_request);
        check_field("busy_res", want.busy_res, out_busy_res);
        check_field("done_res", want.done_res, out_done_res);
        check_field("status", want.status, out_status);
      end
    end
  end

  // Stimulus: directed table, then random phases under several register settings.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) begin
      pace_input();
      send_item(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);
    end
    run_phase(400);
    settle();
    program_regs(8'hFF, 8'd2, 8'd0);
    run_phase(400);
    settle();
    program_regs(8'($urandom), 8'd3, 8'd1);
    run_phase(400);
    settle();
    program_regs(8'h00, 8'd0, 8'd255);
    run_phase(300);
    settle();
    program_regs(8'($urandom), 8'd2, 8'($urandom_range(2, 6)));
    run_phase(300);
    settle();
    program_regs(8'($urandom), 8'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    run_phase(200);
    settle();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS i2c_master_register_transfer_unit");
    end else begin
      $display("FAIL i2c_master_register_transfer_unit");
    end
    $finish;
  end

  // Watchdog in case the block stops responding.
  initial begin
    #20ms;
    $display("FAIL i2c_master_register_transfer_unit");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/i2cm_rt_pkg.sv
hdl/i2c_master_register_transfer_unit.sv
bench/tb.sv
